@@ design/i2cm_pkg.sv @@
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master byte engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

    // action codes on the command input
    localparam logic [2:0] ACT_TICK  = 3'd0;
    localparam logic [2:0] ACT_START = 3'd1;
    localparam logic [2:0] ACT_WRITE = 3'd2;
    localparam logic [2:0] ACT_READ  = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;

    // configuration register map (index is paddr[2])
    localparam logic       REG_HALF_PERIOD = 1'b0;
    localparam logic [7:0] HALF_RESET      = 8'd5;

    // command and result queues
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_START,
        CMD_WRITE,
        CMD_READ,
        CMD_STOP
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind   kind;
        logic [7:0]  tx_byte;
        logic        ack_more;
        logic        scl_sense;
        logic        sda_sense;
    } t_cmd;

    typedef struct packed {
        logic        scl_pull_low;
        logic        sda_pull_low;
        logic        ready_res;
        logic        cmd_done;
        logic        slave_nack;
        logic [7:0]  rx_byte;
    } t_res;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_ST_D,
        PH_WB_LO,
        PH_WB_HI,
        PH_WA_LO,
        PH_WA_WAIT,
        PH_WA_HI,
        PH_RB_LO,
        PH_RB_HI,
        PH_RB_WAIT,
        PH_RA_LO,
        PH_RA_WAIT,
        PH_RA_HI,
        PH_SP_1,
        PH_SP_2,
        PH_SP_3
    } t_phase;

endpackage

@@ design/i2cm_front.sv @@
// ----------------------------------------------------------------------------
// i2cm_front
// Accepts ticks, decodes the action code and queues the decoded command.
// ----------------------------------------------------------------------------
module i2cm_front import i2cm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    output logic       o_full,
    input  logic [2:0] i_action,
    input  logic [7:0] i_tx_byte,
    input  logic       i_ack_more,
    input  logic       i_scl_sense,
    input  logic       i_sda_sense,
    input  logic       i_deq,
    output logic       o_cmd_valid,
    output t_cmd       o_cmd
);

    t_cmd_kind            w_kind;
    t_cmd                 w_cmd;
    t_cmd                 r_mem [QDEPTH];
    logic [QPTR_W-1:0]    r_wptr, r_rptr;
    logic [QCNT_W-1:0]    r_count, n_count;
    logic                 w_push_ok, w_deq_ok;

    always_comb begin
        unique case (i_action)
            ACT_START: w_kind = CMD_START;
            ACT_WRITE: w_kind = CMD_WRITE;
            ACT_READ:  w_kind = CMD_READ;
            ACT_STOP:  w_kind = CMD_STOP;
            default:   w_kind = CMD_NONE;   // plain tick and unused codes
        endcase
    end

    assign w_cmd = '{kind: w_kind, tx_byte: i_tx_byte, ack_more: i_ack_more,
                     scl_sense: i_scl_sense, sda_sense: i_sda_sense};

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_mem[r_rptr];
    assign w_push_ok   = i_push && !o_full;
    assign w_deq_ok    = i_deq && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (w_push_ok && !w_deq_ok) begin
            n_count = r_count + 1'b1;
        end else if (!w_push_ok && w_deq_ok) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_mem[r_wptr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_push_ok) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (w_deq_ok) begin
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

endmodule

@@ design/i2cm_back.sv @@
// ----------------------------------------------------------------------------
// i2cm_back
// Bus sequencer: advances one tick per command and queues the pin/status result.
// ----------------------------------------------------------------------------
module i2cm_back import i2cm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_half_period,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_deq,
    output logic       o_empty,
    input  logic       i_pop,
    output t_res       o_res
);

    t_phase            r_phase, n_phase;
    logic [2:0]        r_bit, n_bit;
    logic [7:0]        r_shift, n_shift;
    logic [7:0]        r_delay, n_delay;
    logic              r_more, n_more;
    logic              r_scl, n_scl;
    logic              r_sda, n_sda;
    logic              r_nack, n_nack;
    logic [7:0]        r_rx, n_rx;
    logic              w_done;

    logic [7:0]        w_load, w_dec;
    logic              w_exp, w_rb_take, w_step;

    t_res              w_res;
    t_res              r_rmem [QDEPTH];
    logic [QPTR_W-1:0] r_rwptr, r_rrptr;
    logic [QCNT_W-1:0] r_rcount, n_rcount;
    logic              w_pop_ok;

    assign w_step = i_cmd_valid && (r_rcount != QCNT_W'(QDEPTH));
    assign o_deq  = w_step;

    // a zero half period behaves as one tick
    assign w_load = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign w_exp  = (r_delay <= 8'd1);
    assign w_dec  = r_delay - 8'd1;
    // read bit sample: stretch check begins on the tick the high delay runs out
    assign w_rb_take = i_cmd.scl_sense &&
                       ((r_phase == PH_RB_WAIT) || ((r_phase == PH_RB_HI) && w_exp));

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_IDLE: begin
                case (i_cmd.kind)
                    CMD_START: n_phase = PH_ST_D;
                    CMD_WRITE: n_phase = PH_WB_LO;
                    CMD_READ:  n_phase = PH_RB_LO;
                    CMD_STOP:  n_phase = PH_SP_1;
                    default:   n_phase = PH_IDLE;
                endcase
            end
            PH_ST_D:    if (w_exp) n_phase = PH_WB_LO;
            PH_WB_LO:   if (w_exp) n_phase = PH_WB_HI;
            PH_WB_HI:   if (w_exp) n_phase = (r_bit == 3'd7) ? PH_WA_LO : PH_WB_LO;
            PH_WA_LO:   if (w_exp) n_phase = PH_WA_WAIT;
            PH_WA_WAIT: if (i_cmd.scl_sense) n_phase = PH_WA_HI;
            PH_WA_HI:   if (w_exp) n_phase = PH_IDLE;
            PH_RB_LO:   if (w_exp) n_phase = PH_RB_HI;
            PH_RB_HI, PH_RB_WAIT: begin
                if (w_rb_take) begin
                    n_phase = (r_bit == 3'd7) ? PH_RA_LO : PH_RB_LO;
                end else if (r_phase == PH_RB_WAIT || w_exp) begin
                    n_phase = PH_RB_WAIT;
                end
            end
            PH_RA_LO:   if (w_exp) n_phase = PH_RA_WAIT;
            PH_RA_WAIT: if (i_cmd.scl_sense) n_phase = PH_RA_HI;
            PH_RA_HI:   if (w_exp) n_phase = PH_IDLE;
            PH_SP_1:    if (w_exp) n_phase = PH_SP_2;
            PH_SP_2:    if (w_exp) n_phase = PH_SP_3;
            PH_SP_3:    if (w_exp) n_phase = PH_IDLE;
            default:    n_phase = PH_IDLE;
        endcase
    end

    // datapath and pin drives
    always_comb begin
        n_bit   = r_bit;
        n_shift = r_shift;
        n_delay = r_delay;
        n_more  = r_more;
        n_scl   = r_scl;
        n_sda   = r_sda;
        n_nack  = r_nack;
        n_rx    = r_rx;
        w_done  = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                case (i_cmd.kind)
                    CMD_START: begin
                        n_shift = i_cmd.tx_byte;
                        n_bit   = '0;
                        n_sda   = 1'b1;
                        n_delay = w_load;
                    end
                    CMD_WRITE: begin
                        n_shift = i_cmd.tx_byte;
                        n_bit   = '0;
                        n_scl   = 1'b1;
                        n_sda   = ~i_cmd.tx_byte[7];
                        n_delay = w_load;
                    end
                    CMD_READ: begin
                        n_shift = '0;
                        n_bit   = '0;
                        n_more  = i_cmd.ack_more;
                        n_scl   = 1'b1;
                        n_sda   = 1'b0;
                        n_delay = w_load;
                    end
                    CMD_STOP: begin
                        n_scl   = 1'b1;
                        n_sda   = 1'b1;
                        n_delay = w_load;
                    end
                    default: ;
                endcase
            end
            PH_ST_D: begin
                if (w_exp) begin
                    n_scl   = 1'b1;
                    n_sda   = ~r_shift[7];
                    n_delay = w_load;
                end else begin
                    n_delay = w_dec;
                end
            end
            PH_WB_LO, PH_RB_LO, PH_SP_1: begin
                if (w_exp) begin
                    n_scl   = 1'b0;
                    n_delay = w_load;
                end else begin
                    n_delay = w_dec;
                end
            end
            PH_WB_HI: begin
                if (w_exp) begin
                    n_shift = {r_shift[6:0], 1'b0};
                    n_scl   = 1'b1;
                    n_delay = w_load;
                    if (r_bit == 3'd7) begin
                        n_bit = '0;
                        n_sda = 1'b0;
                    end else begin
                        n_bit = r_bit + 3'd1;
                        n_sda = ~r_shift[6];
                    end
                end else begin
                    n_delay = w_dec;
                end
            end
            PH_WA_LO, PH_RA_LO: begin
                // ack slot: release SCL, no reload until SCL reads high
                if (w_exp) begin
                    n_scl = 1'b0;
                end else begin
                    n_delay = w_dec;
                end
            end
            PH_WA_WAIT: begin
                if (i_cmd.scl_sense) begin
                    n_nack  = i_cmd.sda_sense;
                    n_delay = w_load;
                end
            end
            PH_WA_HI, PH_SP_3: begin
                if (w_exp) begin
                    w_done = 1'b1;
                end else begin
                    n_delay = w_dec;
                end
            end
            PH_RB_HI, PH_RB_WAIT: begin
                if (w_rb_take) begin
                    n_shift = {r_shift[6:0], i_cmd.sda_sense};
                    n_scl   = 1'b1;
                    n_delay = w_load;
                    if (r_bit == 3'd7) begin
                        n_bit = '0;
                        n_sda = r_more;
                    end else begin
                        n_bit = r_bit + 3'd1;
                    end
                end else if (r_phase == PH_RB_HI && !w_exp) begin
                    n_delay = w_dec;
                end
            end
            PH_RA_WAIT: begin
                if (i_cmd.scl_sense) begin
                    n_delay = w_load;
                end
            end
            PH_RA_HI: begin
                if (w_exp) begin
                    n_rx   = r_shift;
                    w_done = 1'b1;
                end else begin
                    n_delay = w_dec;
                end
            end
            PH_SP_2: begin
                if (w_exp) begin
                    n_sda   = 1'b0;
                    n_delay = w_load;
                end else begin
                    n_delay = w_dec;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_bit   <= '0;
            r_shift <= '0;
            r_delay <= '0;
            r_more  <= 1'b0;
            r_scl   <= 1'b0;
            r_sda   <= 1'b0;
            r_nack  <= 1'b0;
            r_rx    <= '0;
        end else if (w_step) begin
            r_phase <= n_phase;
            r_bit   <= n_bit;
            r_shift <= n_shift;
            r_delay <= n_delay;
            r_more  <= n_more;
            r_scl   <= n_scl;
            r_sda   <= n_sda;
            r_nack  <= n_nack;
            r_rx    <= n_rx;
        end
    end

    // result queue
    assign w_res = '{scl_pull_low: n_scl, sda_pull_low: n_sda,
                     ready_res: (n_phase == PH_IDLE), cmd_done: w_done,
                     slave_nack: n_nack, rx_byte: n_rx};

    assign o_empty  = (r_rcount == '0);
    assign o_res    = r_rmem[r_rrptr];
    assign w_pop_ok = i_pop && !o_empty;

    always_comb begin
        n_rcount = r_rcount;
        if (w_step && !w_pop_ok) begin
            n_rcount = r_rcount + 1'b1;
        end else if (!w_step && w_pop_ok) begin
            n_rcount = r_rcount - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_rmem[r_rwptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rwptr  <= '0;
            r_rrptr  <= '0;
            r_rcount <= '0;
        end else begin
            r_rcount <= n_rcount;
            if (w_step) begin
                r_rwptr <= r_rwptr + 1'b1;
            end
            if (w_pop_ok) begin
                r_rrptr <= r_rrptr + 1'b1;
            end
        end
    end

endmodule

@@ design/i2c_master_byte_engine.sv @@
// ----------------------------------------------------------------------------
// i2c_master_byte_engine
// Open-drain I2C master advanced one tick per input transfer.
// ----------------------------------------------------------------------------
// Each input transfer is one bus tick carrying the sampled SCL/SDA levels and
// an optional command; each gives exactly one result transfer with pin drives
// and status. A tick is taken every clock while both queues flow: the front
// decodes into a two-entry command queue, the sequencer retires one command
// per clock into a two-entry result queue; a tick is registered in the command
// queue, then its result in the result queue, ready to pop. The half-period
// register (byte address 0) is for the user to write over the APB port only while the
// engine is idle (the block does not enforce this); no clearing pass follows reset.
module i2c_master_byte_engine import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // tick input
    input  logic        push,
    output logic        full,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_ack_more,
    input  logic        i_scl_sense,
    input  logic        i_sda_sense,
    // result output
    output logic        empty,
    input  logic        pop,
    output logic        o_scl_pull_low,
    output logic        o_sda_pull_low,
    output logic        o_ready_res,
    output logic        o_cmd_done,
    output logic        o_slave_nack,
    output logic [7:0]  o_rx_byte,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic       w_half_sel;
    logic [7:0] r_half_period;
    logic       w_cmd_valid, w_deq, w_cfg_wr;
    t_cmd       w_cmd;
    t_res       w_res;

    assign pready     = 1'b1;
    assign w_cfg_wr   = psel && penable && pwrite && pready && (paddr[2] == REG_HALF_PERIOD);
    assign w_half_sel = (paddr[2] == REG_HALF_PERIOD);
    assign prdata     = w_half_sel ? {24'd0, r_half_period} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_RESET;
        end else if (w_cfg_wr) begin
            r_half_period <= pwdata[7:0];
        end
    end

    i2cm_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_action    (i_action),
        .i_tx_byte   (i_tx_byte),
        .i_ack_more  (i_ack_more),
        .i_scl_sense (i_scl_sense),
        .i_sda_sense (i_sda_sense),
        .i_deq       (w_deq),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    i2cm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_half_period (r_half_period),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_deq         (w_deq),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_res         (w_res)
    );

    assign o_scl_pull_low = w_res.scl_pull_low;
    assign o_sda_pull_low = w_res.sda_pull_low;
    assign o_ready_res    = w_res.ready_res;
    assign o_cmd_done     = w_res.cmd_done;
    assign o_slave_nack   = w_res.slave_nack;
    assign o_rx_byte      = w_res.rx_byte;

endmodule

@@ design/i2cm_checker.sv @@
// ----------------------------------------------------------------------------
// i2cm_checker
// Port-level checks for the I2C master byte engine.
// ----------------------------------------------------------------------------
module i2cm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic        o_scl_pull_low,
    input logic        o_ready_res,
    input logic        o_cmd_done,
    input logic        pready
);

    // both queues come out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    // a completed command always leaves the engine idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cmd_done) |-> o_ready_res)
        else $error("command done while engine busy");

    // every command ends with SCL released
    a_done_scl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_cmd_done) |-> !o_scl_pull_low)
        else $error("command done with SCL held low");

    // a waiting result is not withdrawn
    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> !empty)
        else $error("result lost without a pop");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind i2c_master_byte_engine i2cm_checker u_i2cm_checker (.*);

@@ tb/i2c_master_byte_engine_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_checker
// Tracks the bus sequencer tick by tick and checks every result transfer.
// ----------------------------------------------------------------------------
// Each accepted tick runs through a cycle-free copy of the sequencer, and the
// predicted pin drives and status go into an in-order queue. Each popped
// result is compared field by field with the oldest prediction. Half-period
// writes on the APB port update the local copy, and read-backs are checked.
module i2c_master_byte_engine_checker import i2cm_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  logic        i_full,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_ack_more,
    input  logic        i_scl_sense,
    input  logic        i_sda_sense,
    input  logic        i_empty,
    input  logic        i_pop,
    input  logic        i_scl_pull_low,
    input  logic        i_sda_pull_low,
    input  logic        i_ready_res,
    input  logic        i_cmd_done,
    input  logic        i_slave_nack,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic [31:0] i_prdata,
    input  logic        i_pready,
    output int          o_errors,
    output int          o_pending,
    output int          o_checked,
    output logic        o_idle
);

    t_phase     ph;
    logic [2:0] bit_idx;
    logic [7:0] shifter;
    logic [7:0] delay_left;
    logic [7:0] half_ticks;
    logic [7:0] rx_hold;
    logic       more_ack;
    logic       scl_low;
    logic       sda_low;
    logic       nack_seen;

    t_res pin_status_q[$];

    function automatic void reload_delay();
        delay_left = (half_ticks == 8'd0) ? 8'd1 : half_ticks;
    endfunction

    function automatic logic delay_done();
        if (delay_left > 8'd1) begin
            delay_left = delay_left - 8'd1;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void begin_data_bit();
        scl_low = 1'b1;
        sda_low = ~shifter[7];
        reload_delay();
        ph = PH_WB_LO;
    endfunction

    // one bus tick; returns the pin drives and status after it
    function automatic t_res advance_bus(input logic [2:0] act, input logic [7:0] tx,
                                         input logic more, input logic scl,
                                         input logic sda);
        t_res r;
        logic done;
        logic sample_rd;
        done      = 1'b0;
        sample_rd = 1'b0;
        case (ph)
            PH_IDLE: begin
                case (act)
                    ACT_START: begin
                        shifter = tx;
                        bit_idx = 3'd0;
                        sda_low = 1'b1;
                        reload_delay();
                        ph = PH_ST_D;
                    end
                    ACT_WRITE: begin
                        shifter = tx;
                        bit_idx = 3'd0;
                        begin_data_bit();
                    end
                    ACT_READ: begin
                        shifter  = 8'd0;
                        bit_idx  = 3'd0;
                        more_ack = more;
                        scl_low  = 1'b1;
                        sda_low  = 1'b0;
                        reload_delay();
                        ph = PH_RB_LO;
                    end
                    ACT_STOP: begin
                        scl_low = 1'b1;
                        sda_low = 1'b1;
                        reload_delay();
                        ph = PH_SP_1;
                    end
                    default: ;
                endcase
            end
            PH_ST_D: if (delay_done()) begin_data_bit();
            PH_WB_LO: if (delay_done()) begin
                scl_low = 1'b0;
                reload_delay();
                ph = PH_WB_HI;
            end
            PH_WB_HI: if (delay_done()) begin
                shifter = shifter << 1;
                if (bit_idx == 3'd7) begin
                    bit_idx = 3'd0;
                    scl_low = 1'b1;
                    sda_low = 1'b0;
                    reload_delay();
                    ph = PH_WA_LO;
                end else begin
                    bit_idx = bit_idx + 3'd1;
                    begin_data_bit();
                end
            end
            PH_WA_LO: if (delay_done()) begin
                scl_low = 1'b0;
                ph = PH_WA_WAIT;
            end
            PH_WA_WAIT: if (scl) begin
                nack_seen = sda;
                reload_delay();
                ph = PH_WA_HI;
            end
            PH_WA_HI: if (delay_done()) begin
                done = 1'b1;
                ph = PH_IDLE;
            end
            PH_RB_LO: if (delay_done()) begin
                scl_low = 1'b0;
                reload_delay();
                ph = PH_RB_HI;
            end
            // stretch check already runs on the tick the delay expires
            PH_RB_HI: if (delay_done()) begin
                ph = PH_RB_WAIT;
                sample_rd = 1'b1;
            end
            PH_RB_WAIT: sample_rd = 1'b1;
            PH_RA_LO: if (delay_done()) begin
                scl_low = 1'b0;
                ph = PH_RA_WAIT;
            end
            PH_RA_WAIT: if (scl) begin
                reload_delay();
                ph = PH_RA_HI;
            end
            PH_RA_HI: if (delay_done()) begin
                rx_hold = shifter;
                done = 1'b1;
                ph = PH_IDLE;
            end
            PH_SP_1: if (delay_done()) begin
                scl_low = 1'b0;
                reload_delay();
                ph = PH_SP_2;
            end
            PH_SP_2: if (delay_done()) begin
                sda_low = 1'b0;
                reload_delay();
                ph = PH_SP_3;
            end
            PH_SP_3: if (delay_done()) begin
                done = 1'b1;
                ph = PH_IDLE;
            end
            default: ph = PH_IDLE;
        endcase
        if (sample_rd && scl) begin
            shifter = {shifter[6:0], sda};
            scl_low = 1'b1;
            reload_delay();
            if (bit_idx == 3'd7) begin
                bit_idx = 3'd0;
                sda_low = more_ack;
                ph = PH_RA_LO;
            end else begin
                bit_idx = bit_idx + 3'd1;
                ph = PH_RB_LO;
            end
        end
        r.scl_pull_low = scl_low;
        r.sda_pull_low = sda_low;
        r.ready_res    = (ph == PH_IDLE);
        r.cmd_done     = done;
        r.slave_nack   = nack_seen;
        r.rx_byte      = rx_hold;
        return r;
    endfunction

    function automatic void compare_field(input string name, input logic [7:0] want,
                                          input logic [7:0] got);
        if (want !== got) begin
            o_errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            ph         = PH_IDLE;
            bit_idx    = 3'd0;
            shifter    = 8'd0;
            delay_left = 8'd0;
            half_ticks = HALF_RESET;
            rx_hold    = 8'd0;
            more_ack   = 1'b0;
            scl_low    = 1'b0;
            sda_low    = 1'b0;
            nack_seen  = 1'b0;
            pin_status_q.delete();
            o_errors   = 0;
            o_checked  = 0;
        end else begin
            if (i_pop && !i_empty) begin
                got.scl_pull_low = i_scl_pull_low;
                got.sda_pull_low = i_sda_pull_low;
                got.ready_res    = i_ready_res;
                got.cmd_done     = i_cmd_done;
                got.slave_nack   = i_slave_nack;
                got.rx_byte      = i_rx_byte;
                if (pin_status_q.size() == 0) begin
                    o_errors++;
                    $display("%0t: result transfer with nothing expected, actual %0h",
                             $time, got);
                end else begin
                    want = pin_status_q.pop_front();
                    compare_field("scl_pull_low", 8'(want.scl_pull_low),
                                  8'(got.scl_pull_low));
                    compare_field("sda_pull_low", 8'(want.sda_pull_low),
                                  8'(got.sda_pull_low));
                    compare_field("ready_res", 8'(want.ready_res), 8'(got.ready_res));
                    compare_field("cmd_done", 8'(want.cmd_done), 8'(got.cmd_done));
                    compare_field("slave_nack", 8'(want.slave_nack), 8'(got.slave_nack));
                    compare_field("rx_byte", want.rx_byte, got.rx_byte);
                    o_checked++;
                end
            end
            if (i_push && !i_full)
                pin_status_q.push_back(advance_bus(i_action, i_tx_byte, i_ack_more,
                                                   i_scl_sense, i_sda_sense));
            if (i_psel && i_penable && i_pready && i_paddr[2] == REG_HALF_PERIOD) begin
                if (i_pwrite)
                    half_ticks = i_pwdata[7:0];
                else
                    compare_field("half period read-back", half_ticks, i_prdata[7:0]);
            end
        end
        o_pending = pin_status_q.size();
        o_idle    = (ph == PH_IDLE);
    end

endmodule

@@ tb/i2c_master_byte_engine_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// i2c_master_byte_engine_test
// Stimulus and verdict for the I2C master byte engine.
// ----------------------------------------------------------------------------
// Drives bus ticks carrying commands, sampled pins and random clock
// stretching, mostly as start / data / stop transactions plus some noise.
// Phases step through several half periods (zero and both extremes among
// them) and through sender gaps and receiver stalls. The checker beside the
// engine predicts and compares; this module only drives and reports.
module i2c_master_byte_engine_test;
    import i2cm_pkg::*;

    localparam logic [2:0] ACT_SPARE_LO = 3'd5;
    localparam logic [2:0] ACT_SPARE_HI = 3'd7;
    localparam logic [2:0] HALF_ADDR    = {REG_HALF_PERIOD, 2'b00};
    localparam int         PHASE_TICKS  = 165;

    logic        i_clk;
    logic        i_rst_n;
    logic        push;
    logic        full;
    logic [2:0]  i_action;
    logic [7:0]  i_tx_byte;
    logic        i_ack_more;
    logic        i_scl_sense;
    logic        i_sda_sense;
    logic        empty;
    logic        pop;
    logic        o_scl_pull_low;
    logic        o_sda_pull_low;
    logic        o_ready_res;
    logic        o_cmd_done;
    logic        o_slave_nack;
    logic [7:0]  o_rx_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int   errors;
    int   pending;
    int   checked;
    logic eng_idle;

    int gap_pct;
    int stall_pct;
    int stretch_pct;
    int tick_count;
    int cmd_count;

    i2c_master_byte_engine dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_action       (i_action),
        .i_tx_byte      (i_tx_byte),
        .i_ack_more     (i_ack_more),
        .i_scl_sense    (i_scl_sense),
        .i_sda_sense    (i_sda_sense),
        .empty          (empty),
        .pop            (pop),
        .o_scl_pull_low (o_scl_pull_low),
        .o_sda_pull_low (o_sda_pull_low),
        .o_ready_res    (o_ready_res),
        .o_cmd_done     (o_cmd_done),
        .o_slave_nack   (o_slave_nack),
        .o_rx_byte      (o_rx_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    i2c_master_byte_engine_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_action       (i_action),
        .i_tx_byte      (i_tx_byte),
        .i_ack_more     (i_ack_more),
        .i_scl_sense    (i_scl_sense),
        .i_sda_sense    (i_sda_sense),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_scl_pull_low (o_scl_pull_low),
        .i_sda_pull_low (o_sda_pull_low),
        .i_ready_res    (o_ready_res),
        .i_cmd_done     (o_cmd_done),
        .i_slave_nack   (o_slave_nack),
        .i_rx_byte      (o_rx_byte),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .i_prdata       (prdata),
        .i_pready       (pready),
        .o_errors       (errors),
        .o_pending      (pending),
        .o_checked      (checked),
        .o_idle         (eng_idle)
    );

    always #4 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        pop <= ($urandom_range(99) >= stall_pct);
    end

    // one tick transfer; the command rides on it only if the engine is idle
    task automatic bus_tick(input logic want, input logic [2:0] act, input logic [7:0] tx,
                            input logic more, output logic carried);
        @(negedge i_clk);
        while ($urandom_range(99) < gap_pct) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        carried = eng_idle;
        push <= 1'b1;
        if (want && carried) begin
            i_action   <= act;
            i_tx_byte  <= tx;
            i_ack_more <= more;
        end else begin
            if (carried)
                i_action <= $urandom_range(1) ? ACT_TICK
                                              : 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
            else
                i_action <= 3'($urandom());
            i_tx_byte  <= 8'($urandom());
            i_ack_more <= 1'($urandom());
        end
        i_scl_sense <= ($urandom_range(99) >= stretch_pct);
        i_sda_sense <= 1'($urandom());
        do @(posedge i_clk); while (full);
        tick_count++;
    endtask

    task automatic issue(input logic [2:0] act, input logic [7:0] tx, input logic more);
        logic carried;
        carried = 1'b0;
        while (!carried)
            bus_tick(1'b1, act, tx, more, carried);
        cmd_count++;
    endtask

    task automatic settle();
        logic carried;
        carried = 1'b0;
        while (!carried)
            bus_tick(1'b0, ACT_TICK, 8'd0, 1'b0, carried);
        @(negedge i_clk);
        push <= 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // half-period write followed by a read-back
    task automatic write_half(input logic [7:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= HALF_ADDR;
        pwdata  <= {24'd0, val};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // start + address, a few data bytes, stop; some noise and missing stops
    task automatic transaction();
        int n;
        if ($urandom_range(99) < 15) begin
            issue(3'($urandom()), 8'($urandom()), 1'($urandom()));
            return;
        end
        issue(ACT_START, 8'($urandom()), 1'b0);
        n = $urandom_range(3, 1);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(1))
                issue(ACT_READ, 8'($urandom()), (i < n - 1));
            else
                issue(ACT_WRITE, 8'($urandom()), 1'($urandom()));
        end
        if ($urandom_range(9) != 0)
            issue(ACT_STOP, 8'($urandom()), 1'($urandom()));
    endtask

    task automatic traffic(input logic [7:0] half, input int gap, input int stall,
                           input logic hold_mid);
        int stop_at;
        write_half(half);
        gap_pct   = gap;
        stall_pct = stall;
        stop_at   = tick_count + PHASE_TICKS;
        while (tick_count < stop_at) begin
            transaction();
            if (hold_mid && tick_count >= stop_at - PHASE_TICKS / 2) begin
                hold_mid = 1'b0;
                @(negedge i_clk);
                push <= 1'b0;
                while (pending != 0)
                    @(negedge i_clk);
            end
        end
        settle();
    endtask

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        pop         = 1'b0;
        i_action    = ACT_TICK;
        i_tx_byte   = 8'd0;
        i_ack_more  = 1'b0;
        i_scl_sense = 1'b1;
        i_sda_sense = 1'b1;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 3'd0;
        pwdata      = 32'd0;
        gap_pct     = 0;
        stall_pct   = 0;
        stretch_pct = 40;
        tick_count  = 0;
        cmd_count   = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset half period, then zero (runs as one tick)
        issue(ACT_START, 8'h00, 1'b0);
        issue(ACT_WRITE, 8'hFF, 1'b0);
        issue(ACT_STOP, 8'h00, 1'b0);
        settle();
        write_half(8'd0);
        issue(ACT_START, 8'hFF, 1'b1);
        issue(ACT_WRITE, 8'h80, 1'b1);
        issue(ACT_WRITE, 8'h01, 1'b0);
        issue(ACT_READ, 8'h00, 1'b1);
        issue(ACT_READ, 8'hFF, 1'b0);
        for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++)
            issue(3'(a), 8'hFF, 1'b1);
        issue(ACT_TICK, 8'h00, 1'b0);
        issue(ACT_STOP, 8'hFF, 1'b1);
        settle();

        stretch_pct = 25;
        traffic(8'd1, 0, 0, 1'b1);
        traffic(8'd2, 86, 0, 1'b0);
        traffic(8'd3, 0, 86, 1'b0);
        // longest half period: a stop only, the other commands take thousands of ticks
        write_half(8'd255);
        gap_pct   = 33;
        stall_pct = 33;
        issue(ACT_STOP, 8'h00, 1'b0);
        settle();
        traffic(8'd1, 33, 33, 1'b0);

        repeat (20) @(negedge i_clk);
        $display("covered %0d ticks, %0d commands, half periods 5, 0, 1, 2, 3 and 255",
                 tick_count, cmd_count);
        $display("%0d results compared under sender gaps, receiver stalls and SCL stretching",
                 checked);
        if (errors == 0 && pending == 0) begin
            $display("i2c_master_byte_engine_test passed");
        end else begin
            if (pending != 0)
                $display("%0t: %0d expected results never arrived", $time, pending);
            $display("i2c_master_byte_engine_test failed");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("%0t: timeout", $time);
        $display("i2c_master_byte_engine_test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
design/i2cm_pkg.sv
design/i2cm_front.sv
design/i2cm_back.sv
design/i2c_master_byte_engine.sv
design/i2cm_checker.sv
tb/i2c_master_byte_engine_checker.sv
tb/i2c_master_byte_engine_test.sv
